FILE: src/apfs_pkg.sv
// Shared constants, widths and result type for the AT parameter field splitter.
package apfs_pkg;

    // Default sizing of the parser
    localparam int MAX_PARAMS_DEF = 16;
    localparam int LINE_BYTES_DEF = 1024;

    // Field widths of the channels
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 5;
    localparam int INDEX_W    = 4;
    localparam int OFS_W      = 10;
    localparam int COUNT_W    = 5;

    // Reset value of the slot-limit register
    localparam logic [CFG_W-1:0] MAX_PARAMS_RESET = 5'd16;

    // Largest offset or length that fits the result fields
    localparam logic [OFS_W-1:0] OFS_MAX = 10'd1023;

    // Characters that steer the scan
    localparam logic [CHAR_W-1:0] CH_EOL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // One result beat
    typedef struct packed {
        logic               param_valid;
        logic [INDEX_W-1:0] param_index;
        logic               param_empty;
        logic [OFS_W-1:0]   param_start;
        logic [OFS_W-1:0]   param_length;
        logic               done_res;
        logic               status;
        logic [COUNT_W-1:0] param_count;
    } res_t;

endpackage

FILE: src/apfs_ifs.sv
// Stream interfaces for characters, parameter results and the slot-limit write.
interface apfs_char_if;
    logic                         valid;
    logic                         ready;
    logic [apfs_pkg::CHAR_W-1:0]  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface apfs_param_if;
    logic                          valid;
    logic                          ready;
    logic                          param_valid;
    logic [apfs_pkg::INDEX_W-1:0]  param_index;
    logic                          param_empty;
    logic [apfs_pkg::OFS_W-1:0]    param_start;
    logic [apfs_pkg::OFS_W-1:0]    param_length;
    logic                          done_res;
    logic                          status;
    logic [apfs_pkg::COUNT_W-1:0]  param_count;

    modport source (output valid, output param_valid, output param_index,
                    output param_empty, output param_start, output param_length,
                    output done_res, output status, output param_count,
                    input ready);
    modport sink   (input valid, input param_valid, input param_index,
                    input param_empty, input param_start, input param_length,
                    input done_res, input status, input param_count,
                    output ready);
endinterface

interface apfs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [apfs_pkg::CFG_W-1:0]  max_params;

    modport source (output valid, output max_params, input ready);
    modport sink   (input valid, input max_params, output ready);
endinterface

FILE: src/at_param_field_splitter.sv
// Top level of the AT parameter field splitter: scan state, result register and skid stage.
//
//  channel  | dir | payload                                   | beat
//  ---------+-----+-------------------------------------------+---------------------------
//  chars    | in  | char_in                                   | one line character
//  params   | out | param_valid .. param_count                | one parameter or line end
//  cfg      | in  | max_params                                | slot-limit write
//
//  One character per cycle unless chars stalls: a taken beat updates the scan state and
//  registers its result (if any) at the same edge, in the skid if the output is stalled.
//  A two-entry output (result register plus skid) keeps chars.ready high while a
//  single result waits; chars stalls only when both entries are full.
//  rst_n clears the scan state, both output entries and sets max_params to 16.
//  cfg is always ready and takes effect on the next character.
module at_param_field_splitter #(
    parameter int MAX_PARAMS = apfs_pkg::MAX_PARAMS_DEF,
    parameter int LINE_BYTES = apfs_pkg::LINE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    apfs_char_if.sink           chars,
    apfs_param_if.source        params,
    apfs_cfg_if.sink            cfg
);

    localparam int POS_W = $clog2(LINE_BYTES);
    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int LIM_W = (CNT_W > apfs_pkg::CFG_W) ? CNT_W : apfs_pkg::CFG_W;
    localparam int EXT_W = POS_W + apfs_pkg::OFS_W + 1;
    localparam int CEX_W = CNT_W + apfs_pkg::COUNT_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_BYTES - 1);
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_PARAMS);

    typedef enum logic [1:0] {
        MODE_SEEK,
        MODE_TEXT,
        MODE_QUOTE
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [POS_W-1:0]              start_reg, start_next;
    logic [POS_W-1:0]              last_reg, last_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          stop_reg, stop_next;
    logic [apfs_pkg::CFG_W-1:0]    max_params_reg;

    apfs_pkg::res_t                out_reg, skid_reg, res;
    logic                          out_valid_reg, skid_valid_reg, res_v;

    logic                          in_fire, out_fire;
    logic [LIM_W-1:0]              mp_ext, limit;
    logic [CNT_W-1:0]              cnt_inc;
    logic [LIM_W-1:0]              cnt_inc_ext;
    logic [CEX_W-1:0]              cnt_cur_wide, cnt_inc_wide;
    logic [EXT_W-1:0]              start_ext, len_ext;
    logic [apfs_pkg::OFS_W-1:0]    start_sat, len_sat;
    logic [apfs_pkg::CHAR_W-1:0]   c;

    assign in_fire   = chars.valid & chars.ready;
    assign out_fire  = out_valid_reg & params.ready;
    assign chars.ready = ~skid_valid_reg;
    assign cfg.ready   = 1'b1;

    // Effective slot limit: zero acts as one, clip at MAX_PARAMS
    assign mp_ext = LIM_W'(max_params_reg);
    always_comb
    begin
        if (mp_ext == '0)
            limit = LIM_W'(1);
        else if (mp_ext > LIM_MAX)
            limit = LIM_MAX;
        else
            limit = mp_ext;
    end

    // Counter views for the narrow result fields and the limit compare
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign cnt_inc_ext  = LIM_W'(cnt_inc);
    assign cnt_cur_wide = CEX_W'(cnt_reg);
    assign cnt_inc_wide = CEX_W'(cnt_inc);

    // Start offset and trimmed length, saturated to the field width
    assign start_ext = EXT_W'(start_reg);
    assign len_ext   = EXT_W'(last_reg) - EXT_W'(start_reg) + EXT_W'(1);
    assign start_sat = (start_ext > EXT_W'(apfs_pkg::OFS_MAX)) ? apfs_pkg::OFS_MAX
                                                               : start_ext[apfs_pkg::OFS_W-1:0];
    assign len_sat   = (len_ext > EXT_W'(apfs_pkg::OFS_MAX)) ? apfs_pkg::OFS_MAX
                                                             : len_ext[apfs_pkg::OFS_W-1:0];

    assign c = chars.char_in;

    // Scan one character: next state and the result it causes
    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        res        = '0;
        res_v      = 1'b0;

        if (stop_reg)
        begin
            // Drop everything up to the end of the line
            if (c == apfs_pkg::CH_EOL)
            begin
                mode_next  = MODE_SEEK;
                cnt_next   = '0;
                start_next = '0;
                last_next  = '0;
                pos_next   = '0;
                stop_next  = 1'b0;
            end
        end
        else if (c == apfs_pkg::CH_EOL)
        begin
            // Line end: report an open text parameter and the summary
            res.param_count = cnt_cur_wide[apfs_pkg::COUNT_W-1:0];
            if (mode_reg == MODE_TEXT)
            begin
                res.param_valid  = 1'b1;
                res.param_index  = cnt_cur_wide[apfs_pkg::INDEX_W-1:0];
                res.param_start  = start_sat;
                res.param_length = len_sat;
                res.param_count  = cnt_inc_wide[apfs_pkg::COUNT_W-1:0];
            end
            res.done_res = 1'b1;
            res.status   = (mode_reg == MODE_QUOTE);
            res_v        = 1'b1;
            mode_next  = MODE_SEEK;
            cnt_next   = '0;
            start_next = '0;
            last_next  = '0;
            pos_next   = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SEEK:
                begin
                    if (c == apfs_pkg::CH_COMMA)
                    begin
                        res.param_valid = 1'b1;
                        res.param_index = cnt_cur_wide[apfs_pkg::INDEX_W-1:0];
                        res.param_empty = 1'b1;
                        res_v           = 1'b1;
                    end
                    else if (c == apfs_pkg::CH_QUOTE)
                    begin
                        start_next = pos_reg;
                        last_next  = pos_reg;
                        mode_next  = MODE_QUOTE;
                    end
                    else if (c != apfs_pkg::CH_SPACE)
                    begin
                        start_next = pos_reg;
                        last_next  = pos_reg;
                        mode_next  = MODE_TEXT;
                    end
                end
                MODE_TEXT:
                begin
                    if (c == apfs_pkg::CH_COMMA)
                    begin
                        res.param_valid  = 1'b1;
                        res.param_index  = cnt_cur_wide[apfs_pkg::INDEX_W-1:0];
                        res.param_start  = start_sat;
                        res.param_length = len_sat;
                        res_v            = 1'b1;
                        mode_next        = MODE_SEEK;
                    end
                    else if (c != apfs_pkg::CH_SPACE)
                        last_next = pos_reg;
                end
                default:
                begin
                    // Inside quotes: commas are text, closing quote returns to text
                    if (c != apfs_pkg::CH_SPACE)
                        last_next = pos_reg;
                    if (c == apfs_pkg::CH_QUOTE)
                        mode_next = MODE_TEXT;
                end
            endcase

            if (pos_reg < POS_MAX)
                pos_next = pos_reg + POS_W'(1);

            // Completed parameter: count it and stop once the slots run out
            if (res_v)
            begin
                cnt_next = cnt_inc;
                if (cnt_inc_ext >= limit)
                begin
                    res.done_res    = 1'b1;
                    res.param_count = cnt_inc_wide[apfs_pkg::COUNT_W-1:0];
                    stop_next       = 1'b1;
                end
            end
        end
    end

    // Hold scan state, slot limit, result register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SEEK;
            cnt_reg        <= '0;
            start_reg      <= '0;
            last_reg       <= '0;
            pos_reg        <= '0;
            stop_reg       <= 1'b0;
            max_params_reg <= apfs_pkg::MAX_PARAMS_RESET;
            out_reg        <= '0;
            skid_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                max_params_reg <= cfg.max_params;

            if (in_fire)
            begin
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                start_reg <= start_next;
                last_reg  <= last_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
            end

            if (!out_valid_reg || out_fire)
            begin
                // Output free: refill from skid first, else from the new beat
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_reg       <= res;
                    out_valid_reg <= in_fire & res_v;
                end
            end
            else if (in_fire && res_v)
            begin
                // Output stalled: park the new result
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Drive the result channel
    assign params.valid        = out_valid_reg;
    assign params.param_valid  = out_reg.param_valid;
    assign params.param_index  = out_reg.param_index;
    assign params.param_empty  = out_reg.param_empty;
    assign params.param_start  = out_reg.param_start;
    assign params.param_length = out_reg.param_length;
    assign params.done_res     = out_reg.done_res;
    assign params.status       = out_reg.status;
    assign params.param_count  = out_reg.param_count;

endmodule

FILE: src/apfs_check.sv
// Port-level checker for the AT parameter field splitter, bound to the top level.
module apfs_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          param_valid,
    input  logic                          param_empty,
    input  logic [apfs_pkg::OFS_W-1:0]    param_start,
    input  logic [apfs_pkg::OFS_W-1:0]    param_length,
    input  logic                          done_res,
    input  logic                          status,
    input  logic [apfs_pkg::COUNT_W-1:0]  param_count
);

    // Stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(param_valid) && $stable(done_res)
            && $stable(param_start) && $stable(param_length) && $stable(param_count))
        else $error("result beat changed while stalled");

    // Every beat reports a parameter or a line end
    a_some: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> param_valid || done_res)
        else $error("empty result beat");

    // Summary fields stay zero until the line is done
    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == 1'b0 && param_count == '0)
        else $error("summary fields set before line end");

    // Empty parameter carries no offset or length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && param_valid && param_empty |-> param_start == '0 && param_length == '0)
        else $error("empty parameter with offset or length");

    // A text parameter has at least one character
    a_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && param_valid && !param_empty |-> param_length != '0)
        else $error("text parameter with zero length");

endmodule

bind at_param_field_splitter apfs_check u_apfs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (params.valid),
    .out_ready    (params.ready),
    .param_valid  (params.param_valid),
    .param_empty  (params.param_empty),
    .param_start  (params.param_start),
    .param_length (params.param_length),
    .done_res     (params.done_res),
    .status       (params.status),
    .param_count  (params.param_count)
);

FILE: sim/at_param_field_splitter_test.sv
// Self-checking testbench for the AT parameter field splitter: lines in, parameter beats checked.
module at_param_field_splitter_test;

    localparam int LINE_BYTES  = apfs_pkg::LINE_BYTES_DEF;
    localparam int SLOTS_MAX   = apfs_pkg::MAX_PARAMS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int CFG_SETTLE  = 4;
    localparam int MAX_REPORTS = 60;

    typedef enum logic [1:0] {SEEK_START, IN_TEXT, IN_QUOTE} scan_mode_t;
    typedef logic [apfs_pkg::CHAR_W-1:0] char_t;
    typedef logic [apfs_pkg::CFG_W-1:0]  cfg_val_t;

    logic clk = 1'b0;
    logic rst_n;

    apfs_char_if  chars_if ();
    apfs_param_if params_if ();
    apfs_cfg_if   cfg_if ();

    at_param_field_splitter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .params (params_if),
        .cfg    (cfg_if)
    );

    // Clock: period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the splitter state
    scan_mode_t         line_mode   = SEEK_START;
    int                 line_params = 0;
    int                 field_first = 0;
    int                 field_last  = 0;
    int                 line_pos    = 0;
    bit                 line_halted = 1'b0;
    cfg_val_t           slot_cfg    = apfs_pkg::MAX_PARAMS_RESET;

    apfs_pkg::res_t pending_params[$];

    int  mismatches    = 0;
    int  chars_sent    = 0;
    int  lines_sent    = 0;
    int  beats_checked = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b1;

    // Build a text parameter beat from the shadow state
    function automatic apfs_pkg::res_t text_param();
        apfs_pkg::res_t r;
        int   len;
        r = '0;
        len = field_last - field_first + 1;
        r.param_valid  = 1'b1;
        r.param_index  = line_params[apfs_pkg::INDEX_W-1:0];
        r.param_empty  = 1'b0;
        r.param_start  = (field_first > apfs_pkg::OFS_MAX) ? apfs_pkg::OFS_MAX
                                                           : field_first[apfs_pkg::OFS_W-1:0];
        r.param_length = (len > apfs_pkg::OFS_MAX) ? apfs_pkg::OFS_MAX
                                                   : len[apfs_pkg::OFS_W-1:0];
        return r;
    endfunction

    // Advance the shadow state by one character; return 1 when a beat is due
    function automatic bit split_char(input char_t c, output apfs_pkg::res_t r);
        bit emit;
        int lim;
        emit = 1'b0;
        r = '0;
        if (line_halted)
        begin
            if (c == apfs_pkg::CH_EOL)
            begin
                line_mode   = SEEK_START;
                line_params = 0;
                field_first = 0;
                field_last  = 0;
                line_pos    = 0;
                line_halted = 1'b0;
            end
            return 1'b0;
        end
        // End of line: close open text, report the summary
        if (c == apfs_pkg::CH_EOL)
        begin
            if (line_mode == IN_TEXT)
            begin
                r = text_param();
                line_params++;
            end
            r.done_res    = 1'b1;
            r.status      = (line_mode == IN_QUOTE);
            r.param_count = line_params[apfs_pkg::COUNT_W-1:0];
            line_mode   = SEEK_START;
            line_params = 0;
            field_first = 0;
            field_last  = 0;
            line_pos    = 0;
            return 1'b1;
        end
        case (line_mode)
            SEEK_START:
            begin
                if (c == apfs_pkg::CH_COMMA)
                begin
                    r.param_valid = 1'b1;
                    r.param_index = line_params[apfs_pkg::INDEX_W-1:0];
                    r.param_empty = 1'b1;
                    emit = 1'b1;
                end
                else if (c != apfs_pkg::CH_SPACE)
                begin
                    field_first = line_pos;
                    field_last  = line_pos;
                    line_mode   = (c == apfs_pkg::CH_QUOTE) ? IN_QUOTE : IN_TEXT;
                end
            end
            IN_TEXT:
            begin
                if (c == apfs_pkg::CH_COMMA)
                begin
                    r = text_param();
                    emit = 1'b1;
                    line_mode = SEEK_START;
                end
                else if (c != apfs_pkg::CH_SPACE)
                    field_last = line_pos;
            end
            default:
            begin
                if (c != apfs_pkg::CH_SPACE)
                    field_last = line_pos;
                if (c == apfs_pkg::CH_QUOTE)
                    line_mode = IN_TEXT;
            end
        endcase
        if (line_pos < LINE_BYTES - 1)
            line_pos++;
        if (!emit)
            return 1'b0;
        // Stop the line once the slots are used up
        line_params++;
        lim = (slot_cfg == 0) ? 1 : ((slot_cfg > SLOTS_MAX) ? SLOTS_MAX : int'(slot_cfg));
        if (line_params >= lim)
        begin
            r.done_res    = 1'b1;
            r.status      = 1'b0;
            r.param_count = line_params[apfs_pkg::COUNT_W-1:0];
            line_halted   = 1'b1;
        end
        return 1'b1;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch in %s at beat %0d: got %0h, want %0h",
                     what, beats_checked, got, want);
    endtask

    // Predict on every accepted character, track slot-limit writes
    always @(posedge clk)
    begin
        apfs_pkg::res_t r;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                slot_cfg = cfg_if.max_params;
            if (chars_if.valid && chars_if.ready)
            begin
                if (split_char(chars_if.char_in, r))
                    pending_params.push_back(r);
            end
        end
    end

    // Compare every accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        apfs_pkg::res_t got;
        apfs_pkg::res_t want;
        if (rst_n && params_if.valid && params_if.ready)
        begin
            got = {params_if.param_valid, params_if.param_index, params_if.param_empty,
                   params_if.param_start, params_if.param_length, params_if.done_res,
                   params_if.status, params_if.param_count};
            if (pending_params.size() == 0)
                report_mismatch("unexpected beat", int'(got[31:0]), 0);
            else
            begin
                want = pending_params.pop_front();
                if (got.param_valid !== want.param_valid)
                    report_mismatch("param_valid", int'(got.param_valid),
                                    int'(want.param_valid));
                if (got.param_index !== want.param_index)
                    report_mismatch("param_index", int'(got.param_index),
                                    int'(want.param_index));
                if (got.param_empty !== want.param_empty)
                    report_mismatch("param_empty", int'(got.param_empty),
                                    int'(want.param_empty));
                if (got.param_start !== want.param_start)
                    report_mismatch("param_start", int'(got.param_start),
                                    int'(want.param_start));
                if (got.param_length !== want.param_length)
                    report_mismatch("param_length", int'(got.param_length),
                                    int'(want.param_length));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.param_count !== want.param_count)
                    report_mismatch("param_count", int'(got.param_count),
                                    int'(want.param_count));
            end
            beats_checked++;
        end
    end

    // Drop the run at the cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: stall in random bursts while idling is on
    initial
    begin
        int stall;
        stall = 0;
        params_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                params_if.ready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 7) - 1;
                params_if.ready <= 1'b0;
            end
            else
                params_if.ready <= 1'b1;
        end
    end

    // Send one character beat, then maybe hold off for a burst
    task automatic send_char(input char_t c);
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        chars_sent++;
        if (c == apfs_pkg::CH_EOL)
            lines_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Hold the sender until every predicted beat has come out
    task automatic wait_drained();
        if (chars_if.valid)
            chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_params.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_slot_limit(input cfg_val_t v);
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.max_params <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Ordinary text character: sometimes a space, else any nonzero byte but the steering ones
    function automatic char_t text_char();
        char_t c;
        if ($urandom_range(0, 4) == 0)
            return apfs_pkg::CH_SPACE;
        do
            c = char_t'($urandom_range(1, 255));
        while (c == apfs_pkg::CH_COMMA || c == apfs_pkg::CH_QUOTE || c == apfs_pkg::CH_SPACE);
        return c;
    endfunction

    // Well-formed line with random content, a few ending inside a quote
    task automatic send_random_line();
        int  n_par;
        bit  open_quote;
        char_t c;
        open_quote = 1'b0;
        n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
        for (int i = 0; i < n_par && !open_quote; i++)
        begin
            repeat ($urandom_range(0, 2)) send_char(apfs_pkg::CH_SPACE);
            case ($urandom_range(0, 5))
                0: ;
                1, 2:
                begin
                    send_char(apfs_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        c = ($urandom_range(0, 3) == 0) ? apfs_pkg::CH_COMMA
                                                        : char_t'($urandom_range(1, 255));
                        send_char((c == apfs_pkg::CH_QUOTE) ? apfs_pkg::CH_COMMA : c);
                    end
                    if (i == n_par - 1 && $urandom_range(0, 4) == 0)
                        open_quote = 1'b1;
                    else
                    begin
                        send_char(apfs_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 2)) send_char(text_char());
                    end
                end
                default:
                    repeat ($urandom_range(1, 6)) send_char(text_char());
            endcase
            if (!open_quote)
            begin
                repeat ($urandom_range(0, 2)) send_char(apfs_pkg::CH_SPACE);
                if (i != n_par - 1 || $urandom_range(0, 2) == 0)
                    send_char(apfs_pkg::CH_COMMA);
            end
        end
        send_char(apfs_pkg::CH_EOL);
    endtask

    // Noise line: any bytes, zeros included, steering characters weighted up
    task automatic send_noise_line();
        char_t c;
        repeat ($urandom_range(1, 30))
        begin
            case ($urandom_range(0, 7))
                0: c = apfs_pkg::CH_COMMA;
                1: c = apfs_pkg::CH_QUOTE;
                2: c = apfs_pkg::CH_SPACE;
                3: c = ($urandom_range(0, 3) == 0) ? apfs_pkg::CH_EOL : apfs_pkg::CH_COMMA;
                default: c = char_t'($urandom_range(0, 255));
            endcase
            send_char(c);
        end
        send_char(apfs_pkg::CH_EOL);
    endtask

    // Leading/trailing spaces, bare comma, quoted comma, trailing empty, empty line
    task automatic test_basic_fields();
        send_text("  ab ,,\"x,y\" q ,");
        send_char(apfs_pkg::CH_EOL);
        send_char(apfs_pkg::CH_EOL);
        send_text(",");
        send_char(apfs_pkg::CH_EOL);
        send_char(8'hFF);
        send_char(apfs_pkg::CH_EOL);
    endtask

    task automatic test_open_quote();
        send_text("a, \"b,c");
        send_char(apfs_pkg::CH_EOL);
    endtask

    // Limit 1, 0 (acts as 1), 31 (acts as the maximum), back to 16
    task automatic test_slot_limits();
        write_slot_limit(5'd1);
        send_text("a,b\",");
        send_char(apfs_pkg::CH_EOL);
        send_text("x");
        send_char(apfs_pkg::CH_EOL);
        write_slot_limit(5'd0);
        send_text(",,");
        send_char(apfs_pkg::CH_EOL);
        write_slot_limit(5'd31);
        repeat (18) send_char(apfs_pkg::CH_COMMA);
        send_text("z");
        send_char(apfs_pkg::CH_EOL);
        write_slot_limit(5'd16);
        repeat (16) send_text("k,");
        send_char(apfs_pkg::CH_EOL);
    endtask

    // Lower the limit under the count already reached in the middle of a line
    task automatic test_limit_lowered();
        send_text("a,b,c,");
        write_slot_limit(5'd2);
        send_text("d,e");
        send_char(apfs_pkg::CH_EOL);
        write_slot_limit(5'd16);
    endtask

    // Saturation of position, start and length
    task automatic test_long_lines();
        repeat (1030) send_char("x");
        send_text(" ,c");
        send_char(apfs_pkg::CH_EOL);
    endtask

    // Random lines over several slot limits, mostly well formed
    task automatic test_random_lines();
        cfg_val_t limits[6];
        int stop_at;
        limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd0, 5'd0};
        limits[4] = cfg_val_t'($urandom_range(0, 31));
        limits[5] = cfg_val_t'($urandom_range(2, 16));
        foreach (limits[p])
        begin
            write_slot_limit(limits[p]);
            stop_at = chars_sent + 20;
            while (chars_sent < stop_at)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise_line();
                else
                    send_random_line();
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        int stop_at;
        write_slot_limit(5'd16);
        idle_on = 1'b0;
        stop_at = chars_sent + 40;
        while (chars_sent < stop_at)
            send_random_line();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        chars_if.valid    <= 1'b0;
        chars_if.char_in  <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.max_params <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_fields();
        test_open_quote();
        test_slot_limits();
        test_limit_lowered();
        test_long_lines();
        test_random_lines();
        test_steady_stream();

        // Drain and let the pipeline settle
        if (chars_if.valid)
            chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_params.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("tb: %0d characters in %0d lines, %0d result beats checked, %0d mismatches",
                 chars_sent, lines_sent, beats_checked, mismatches);
        $display("tb: covered quoting, empty and trailing parameters, slot limits 0..31, saturation");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/apfs_pkg.sv
src/apfs_ifs.sv
src/at_param_field_splitter.sv
src/apfs_check.sv
sim/at_param_field_splitter_test.sv
